// ===== rtl/tkpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-key priority queue.
package tkpq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 16;
  localparam int unsigned AmountW    = 32;
  localparam int unsigned ScoreW     = 10;
  localparam int unsigned StatusW    = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [StatusW-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [AmountW-1:0] amount;
    logic [ScoreW-1:0]  score;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== rtl/tkpq_cell.sv =====
`timescale 1ns / 1ps
// One slot of the sorted queue: compares against the new entry and shifts.
module tkpq_cell (
  input  logic                clk_i,
  input  tkpq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  tkpq_pkg::entry_t    new_i,
  input  tkpq_pkg::entry_t    left_i,
  input  logic                left_ahead_i,
  input  tkpq_pkg::entry_t    right_i,
  output tkpq_pkg::entry_t    entry_o,
  output logic                ahead_o
);

  tkpq_pkg::entry_t entry_q, entry_d;

  // stored entry stays ahead of the new one
  assign ahead_o = valid_i &&
                   ((entry_q.amount > new_i.amount) ||
                    ((entry_q.amount == new_i.amount) && (entry_q.score >= new_i.score)));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (!ahead_o) begin
        if (left_ahead_i) begin
          entry_d = new_i;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/two_key_priority_queue.sv =====
`timescale 1ns / 1ps
// Top level of the two-key priority queue: cell chain, fill count, result register.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: command_i
//   selects insert or pop; entry_id_i, amount_i, score_i are the entry.
//   Output channel (out_valid_o/out_ready_i) returns one result per request:
//   status, popped entry (zero unless a pop succeeded) and occupancy.
//   Entries are kept sorted by descending amount, then descending score,
//   first-in among full ties. Every cell compares with the new entry in
//   parallel, so the whole chain updates at once; the result appears the
//   cycle after acceptance. One request per cycle is sustained while the
//   receiver takes results; the single result register sets that limit.
//   If the receiver stalls, the result is held and in_ready_o drops until
//   it is taken. Reset empties the queue and clears the output valid; slot
//   contents are not cleared.
module two_key_priority_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [tkpq_pkg::IdW-1:0]            entry_id_i,
  input  logic [tkpq_pkg::AmountW-1:0]        amount_i,
  input  logic [tkpq_pkg::ScoreW-1:0]         score_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tkpq_pkg::StatusW-1:0]        status_o,
  output logic [tkpq_pkg::IdW-1:0]            out_id_o,
  output logic [tkpq_pkg::AmountW-1:0]        out_amount_o,
  output logic [tkpq_pkg::ScoreW-1:0]         out_score_o,
  output logic [tkpq_pkg::CntW-1:0]           occupancy_o
);

  localparam int unsigned Depth = tkpq_pkg::QueueDepth;
  localparam int unsigned CntW  = tkpq_pkg::CntW;

  logic                   accept;
  logic                   is_full, is_empty;
  tkpq_pkg::cell_ctrl_t   ctrl;
  tkpq_pkg::entry_t       new_entry;
  tkpq_pkg::entry_t       cell_entry [Depth];
  logic [Depth-1:0]       cell_ahead;

  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [tkpq_pkg::StatusW-1:0] status_q, status_d;
  tkpq_pkg::entry_t       out_entry_q, out_entry_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(Depth));
  assign is_empty   = (count_q == '0);

  assign new_entry.id     = entry_id_i;
  assign new_entry.amount = amount_i;
  assign new_entry.score  = score_i;

  assign ctrl.insert = accept && (command_i == tkpq_pkg::CMD_INSERT) && !is_full;
  assign ctrl.pop    = accept && (command_i == tkpq_pkg::CMD_POP) && !is_empty;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    tkpq_pkg::entry_t left_entry, right_entry;
    logic             left_ahead;
    logic             slot_valid;

    assign slot_valid = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_ahead = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ahead = cell_ahead[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    tkpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (slot_valid),
      .new_i        (new_entry),
      .left_i       (left_entry),
      .left_ahead_i (left_ahead),
      .right_i      (right_entry),
      .entry_o      (cell_entry[i]),
      .ahead_o      (cell_ahead[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    out_entry_d = out_entry_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      out_entry_d = '0;
      status_d    = tkpq_pkg::STATUS_DONE;
      case (command_i)
        tkpq_pkg::CMD_INSERT: begin
          if (is_full) begin
            status_d = tkpq_pkg::STATUS_FULL;
          end
        end
        tkpq_pkg::CMD_POP: begin
          if (is_empty) begin
            status_d = tkpq_pkg::STATUS_EMPTY;
          end else begin
            out_entry_d = cell_entry[0];
          end
        end
        default: begin
          status_d = tkpq_pkg::STATUS_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  logic [CntW-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_entry_q <= out_entry_d;
    if (accept) begin
      occ_q <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_id_o     = out_entry_q.id;
  assign out_amount_o = out_entry_q.amount;
  assign out_score_o  = out_entry_q.score;
  assign occupancy_o  = occ_q;

endmodule

// ===== tb/sv/two_key_priority_queue_test.sv =====
`timescale 1ns / 1ps
// Testbench for two_key_priority_queue: directed and random requests checked against a sorted-queue model.
module two_key_priority_queue_test;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned QueueDepth = tkpq_pkg::QueueDepth;
  localparam int unsigned CntW       = tkpq_pkg::CntW;
  localparam int unsigned IdW        = tkpq_pkg::IdW;
  localparam int unsigned AmountW    = tkpq_pkg::AmountW;
  localparam int unsigned ScoreW     = tkpq_pkg::ScoreW;
  localparam int unsigned StatusW    = tkpq_pkg::StatusW;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     id;
    logic [AmountW-1:0] amount;
    logic [ScoreW-1:0]  score;
    logic [CntW-1:0]    occupancy;
  } queue_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               command_i   = tkpq_pkg::CMD_INSERT;
  logic [IdW-1:0]     entry_id_i  = '0;
  logic [AmountW-1:0] amount_i    = '0;
  logic [ScoreW-1:0]  score_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [StatusW-1:0] status_o;
  logic [IdW-1:0]     out_id_o;
  logic [AmountW-1:0] out_amount_o;
  logic [ScoreW-1:0]  out_score_o;
  logic [CntW-1:0]    occupancy_o;

  tkpq_pkg::entry_t model_slots [QueueDepth];
  int unsigned   model_fill = 0;
  queue_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   stall_left = 0;
  bit            idle_enable = 1'b1;

  two_key_priority_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .entry_id_i  (entry_id_i),
    .amount_i    (amount_i),
    .score_i     (score_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .out_id_o    (out_id_o),
    .out_amount_o(out_amount_o),
    .out_score_o (out_score_o),
    .occupancy_o (occupancy_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic queue_result_t predict_queue_result(logic cmd, tkpq_pkg::entry_t item);
    queue_result_t res;
    int unsigned   pos;
    int unsigned   i;
    res = '0;
    if (cmd == tkpq_pkg::CMD_INSERT) begin
      if (model_fill >= QueueDepth) begin
        res.status = tkpq_pkg::STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < model_fill &&
               (model_slots[pos].amount > item.amount ||
                (model_slots[pos].amount == item.amount &&
                 model_slots[pos].score >= item.score)))
          pos++;
        for (i = model_fill; i > pos; i--) model_slots[i] = model_slots[i-1];
        model_slots[pos] = item;
        model_fill++;
        res.status = tkpq_pkg::STATUS_DONE;
      end
    end else begin
      if (model_fill == 0) begin
        res.status = tkpq_pkg::STATUS_EMPTY;
      end else begin
        res.status = tkpq_pkg::STATUS_DONE;
        res.id     = model_slots[0].id;
        res.amount = model_slots[0].amount;
        res.score  = model_slots[0].score;
        for (i = 1; i < model_fill; i++) model_slots[i-1] = model_slots[i];
        model_fill--;
      end
    end
    res.occupancy = model_fill[CntW-1:0];
    return res;
  endfunction

  function automatic logic [AmountW-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 3) * 1000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return ScoreW'(500 + $urandom_range(0, 2));
      default: return ScoreW'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic send_request(logic cmd, logic [IdW-1:0] id, logic [AmountW-1:0] amt,
                              logic [ScoreW-1:0] scr);
    tkpq_pkg::entry_t item;
    item.id     = id;
    item.amount = amt;
    item.score  = scr;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    entry_id_i <= id;
    amount_i   <= amt;
    score_i    <= scr;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_results.push_back(predict_queue_result(cmd, item));
  endtask

  task automatic send_random(int unsigned insert_pct);
    send_request(($urandom_range(0, 99) < insert_pct) ? tkpq_pkg::CMD_INSERT : tkpq_pkg::CMD_POP,
                 IdW'($urandom_range(0, 65535)), pick_amount(), pick_score());
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // pop on empty, key extremes, ties on both keys
  task automatic test_directed_cases();
    send_request(tkpq_pkg::CMD_POP, 16'hffff, '1, '1);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0000, '1, '1);
    send_request(tkpq_pkg::CMD_INSERT, 16'hffff, '0, '0);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0001, 32'd1000, 10'd700);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0002, 32'd1000, 10'd700);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0003, 32'd1000, 10'd700);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0004, 32'd1000, 10'd701);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0005, 32'd1000, 10'd699);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0006, 32'd1001, 10'd0);
    send_request(tkpq_pkg::CMD_INSERT, 16'h0007, 32'd999, 10'd1023);
    repeat (10) send_request(tkpq_pkg::CMD_POP, '0, '0, '0);
    send_request(tkpq_pkg::CMD_POP, '0, '0, '0);
  endtask

  // fill to capacity, refused inserts, refill at the top, empty again
  task automatic test_full_queue();
    drain_results();
    repeat (QueueDepth) send_random(100);
    repeat (3) send_random(100);
    repeat (2) send_random(0);
    repeat (3) send_random(100);
    repeat (QueueDepth + 2) send_random(0);
  endtask

  task automatic test_random_mix();
    int unsigned pct_table [6] = '{30, 50, 70, 90, 50, 60};
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 6) drain_results();
      repeat (50) send_random(pct_table[phase % 6]);
    end
  endtask

  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (100) send_random(55);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    queue_result_t exp_res;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d id %h amount %h score %0d occ %0d",
                   status_o, out_id_o, out_amount_o, out_score_o, occupancy_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status || out_id_o !== exp_res.id ||
            out_amount_o !== exp_res.amount || out_score_o !== exp_res.score ||
            occupancy_o !== exp_res.occupancy) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("exp: status %0d id %h amount %h score %0d occ %0d",
                     exp_res.status, exp_res.id, exp_res.amount, exp_res.score,
                     exp_res.occupancy);
            $display("got: status %0d id %h amount %h score %0d occ %0d",
                     status_o, out_id_o, out_amount_o, out_score_o, occupancy_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("two_key_priority_queue: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_full_queue();
    test_random_mix();
    test_back_to_back();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("two_key_priority_queue: match");
    end else begin
      $display("two_key_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tkpq_pkg.sv
rtl/tkpq_cell.sv
rtl/two_key_priority_queue.sv
tb/sv/two_key_priority_queue_test.sv
